// ===== hw/rtl/b32d_pkg.sv =====
`timescale 1ns / 1ps
// shared types, status codes and alphabet lookup for the lowercase base32 decoder
// no dependencies
package b32d_pkg;

  localparam int unsigned FifoDepth = 4;
  localparam int unsigned PtrW      = $clog2(FifoDepth);
  localparam int unsigned CntW      = $clog2(FifoDepth + 1);

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_BAD_CHR = 2'd1;
  localparam logic [1:0] STATUS_PAD     = 2'd2;

  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // one result item
  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
    logic [1:0] status;
    logic       last_result;
  } res_t;

  // decoder state between items; pending bits are always masked to cnt
  typedef struct packed {
    logic [6:0] bits;
    logic [2:0] cnt;
    logic       err;
  } dec_state_t;

  typedef struct packed {
    logic       ok;
    logic [4:0] value;
  } sym_t;

  function automatic sym_t sym_lookup(input logic [7:0] c);
    sym_t s;
    s.ok    = 1'b0;
    s.value = 5'd0;
    if (c inside {[8'h61:8'h7a]}) begin
      s.ok    = 1'b1;
      s.value = 5'(c - 8'h61);
    end else if (c inside {[8'h32:8'h37]}) begin
      s.ok    = 1'b1;
      s.value = 5'(c - 8'h32 + 8'd26);
    end
    return s;
  endfunction

endpackage

// ===== hw/rtl/base32_lower_stream_decoder.sv =====
`timescale 1ns / 1ps
// streaming lowercase base32 decoder, one character per item
// results of an accepted item are written into the registered result queue and offered from its head
// throughput: one item per cycle while the queue has room for two results; the single
//   result port moves one result per cycle, so a byte and a status from one item leave separately
// reset: asynchronous active low, clears bit buffer, count, error and queue
// depends on b32d_pkg, b32d_step, b32d_res_fifo
module base32_lower_stream_decoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] char_code_i,
  input  logic       is_last_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       kind_o,
  output logic [7:0] data_byte_o,
  output logic [1:0] status_o,
  output logic       last_result_o
);

  b32d_pkg::dec_state_t state_q, state_d, step_state;
  b32d_pkg::res_t       res0, res1, head;
  logic [1:0]           n_res, push_n;
  logic                 accept;

  b32d_step u_step (
    .state_i     (state_q),
    .char_code_i (char_code_i),
    .is_last_i   (is_last_i),
    .state_o     (step_state),
    .res0_o      (res0),
    .res1_o      (res1),
    .n_res_o     (n_res)
  );

  assign accept  = in_valid_i && in_ready_o;
  assign push_n  = accept ? n_res : 2'd0;
  assign state_d = accept ? step_state : state_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else begin
      state_q <= state_d;
    end
  end

  b32d_res_fifo u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_n_i (push_n),
    .push0_i  (res0),
    .push1_i  (res1),
    .room2_o  (in_ready_o),
    .valid_o  (out_valid_o),
    .pop_i    (out_ready_i),
    .head_o   (head)
  );

  assign kind_o        = head.kind;
  assign data_byte_o   = head.data_byte;
  assign status_o      = head.status;
  assign last_result_o = head.last_result;

endmodule

// ===== hw/rtl/b32d_step.sv =====
`timescale 1ns / 1ps
// per-item decode: alphabet lookup, bit buffer shift, byte and status results
// depends on b32d_pkg
module b32d_step (
  input  b32d_pkg::dec_state_t state_i,
  input  logic [7:0]           char_code_i,
  input  logic                 is_last_i,
  output b32d_pkg::dec_state_t state_o,
  output b32d_pkg::res_t       res0_o,
  output b32d_pkg::res_t       res1_o,
  output logic [1:0]           n_res_o
);

  b32d_pkg::sym_t       sym;
  b32d_pkg::dec_state_t nxt;
  b32d_pkg::res_t       byte_res;
  b32d_pkg::res_t       stat_res;
  logic [11:0]          merged;
  logic [3:0]           cnt_sum;
  logic [2:0]           shamt;
  logic [6:0]           mask;
  logic                 has_byte;

  always_comb begin
    sym      = b32d_pkg::sym_lookup(char_code_i);
    merged   = {state_i.bits, sym.value};
    cnt_sum  = {1'b0, state_i.cnt} + 4'd5;
    shamt    = 3'(cnt_sum - 4'd8);
    nxt      = state_i;
    has_byte = 1'b0;

    byte_res             = '0;
    byte_res.kind        = b32d_pkg::KIND_DATA;
    byte_res.data_byte   = merged[shamt +: 8];

    if (!state_i.err) begin
      if (!sym.ok) begin
        nxt.err = 1'b1;
      end else if (cnt_sum >= 4'd8) begin
        has_byte = 1'b1;
        nxt.cnt  = shamt;
      end else begin
        nxt.cnt = cnt_sum[2:0];
      end
      if (sym.ok) begin
        for (int i = 0; i < 7; i++) begin
          mask[i] = (3'(i) < nxt.cnt);
        end
        nxt.bits = merged[6:0] & mask;
      end else begin
        mask = '0;
      end
    end else begin
      mask = '0;
    end

    stat_res             = '0;
    stat_res.kind        = b32d_pkg::KIND_STATUS;
    stat_res.last_result = 1'b1;
    if (nxt.err) begin
      stat_res.status = b32d_pkg::STATUS_BAD_CHR;
    end else if (nxt.bits != 7'd0) begin
      stat_res.status = b32d_pkg::STATUS_PAD;
    end else begin
      stat_res.status = b32d_pkg::STATUS_OK;
    end

    // byte goes first when both are produced
    res0_o  = has_byte ? byte_res : stat_res;
    res1_o  = stat_res;
    n_res_o = 2'(has_byte) + 2'(is_last_i);
    state_o = is_last_i ? '0 : nxt;
  end

endmodule

// ===== hw/rtl/b32d_res_fifo.sv =====
`timescale 1ns / 1ps
// small result queue: takes up to two items per cycle, hands out one
// depends on b32d_pkg
module b32d_res_fifo (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [1:0]                push_n_i,
  input  b32d_pkg::res_t            push0_i,
  input  b32d_pkg::res_t            push1_i,
  output logic                      room2_o,
  output logic                      valid_o,
  input  logic                      pop_i,
  output b32d_pkg::res_t            head_o
);

  b32d_pkg::res_t                  mem_q [b32d_pkg::FifoDepth];
  logic [b32d_pkg::PtrW-1:0]       wr_q, wr_d, rd_q, rd_d;
  logic [b32d_pkg::CntW-1:0]       cnt_q, cnt_d;
  logic                            pop;

  assign pop     = pop_i && valid_o;
  assign valid_o = (cnt_q != '0);
  assign room2_o = (cnt_q <= b32d_pkg::CntW'(b32d_pkg::FifoDepth - 2));
  assign head_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q + b32d_pkg::PtrW'(push_n_i);
    rd_d  = rd_q + b32d_pkg::PtrW'(pop);
    cnt_d = cnt_q + b32d_pkg::CntW'(push_n_i) - b32d_pkg::CntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_n_i != 2'd0) begin
      mem_q[wr_q] <= push0_i;
    end
    if (push_n_i == 2'd2) begin
      mem_q[b32d_pkg::PtrW'(wr_q + 1'b1)] <= push1_i;
    end
  end

endmodule
